// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Both macros sample on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PCTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define PCTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/pctd_pkg.sv -----
`default_nettype none

package pctd_pkg;

    // Widths of the tested value and of the trial-division datapath.
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIV_W   = 17;   // divisor reaches 65536
    localparam int unsigned SQ_W    = 33;   // divisor squared reaches 2**32
    localparam int unsigned REM_W   = 16;   // remainder stays below 65536
    localparam int unsigned STEP_W  = 5;    // counts the 32 remainder steps
    localparam int unsigned TALLY_W = 4;

    localparam logic [VALUE_W-1:0] SMALLEST_PRIME = 32'd2;
    localparam logic [DIV_W-1:0]   FIRST_DIVISOR  = 17'd2;
    localparam logic [SQ_W-1:0]    FIRST_SQUARE   = 33'd4;
    localparam logic [TALLY_W-1:0] TALLY_MAX      = 4'd15;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    // Request to the remainder unit.
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [DIV_W-1:0]   divisor;
    } rem_cmd_t;

    // Status from the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_sts_t;

endpackage

`default_nettype wire

// ----- design/pctd_rem.sv -----
`default_nettype none

// Bit-serial restoring remainder unit: one dividend bit per cycle.
module pctd_rem
    import pctd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rem_cmd_t cmd,
    output rem_sts_t      sts
);

    logic               busy_reg;
    logic               done_reg;
    logic               zero_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [VALUE_W-1:0] shift_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   divisor_reg;

    logic [DIV_W-1:0]   trial;
    logic [REM_W-1:0]   rem_next;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        trial = {rem_reg, shift_reg[VALUE_W-1]};
        if (trial >= divisor_reg) begin
            rem_next = REM_W'(trial - divisor_reg);
        end else begin
            rem_next = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg    <= 1'b1;
                step_reg    <= STEP_W'(VALUE_W - 1);
                shift_reg   <= cmd.dividend;
                rem_reg     <= '0;
                divisor_reg <= cmd.divisor;
            end else if (busy_reg) begin
                rem_reg   <= rem_next;
                shift_reg <= shift_reg << 1;
                step_reg  <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    zero_reg <= (rem_next == '0);
                end
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.zero = zero_reg;

endmodule

`default_nettype wire

// ----- design/pctd_seq.sv -----
`default_nettype none

// Trial-division sequencer: walks the divisors and keeps the running square.
module pctd_seq
    import pctd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    idle,
    output logic                    res_valid,
    output logic                    res_prime,
    input  wire logic               res_take,
    output rem_cmd_t                cmd,
    input  wire rem_sts_t           sts
);

    seq_state_t         state_reg, state_next;
    logic [VALUE_W-1:0] value_reg;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic               prime_reg, prime_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= value;
        end
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    // Next state, next divisor and square, and the request to the remainder unit.
    always_comb begin
        state_next   = state_reg;
        div_next     = div_reg;
        sq_next      = sq_reg;
        prime_next   = prime_reg;
        cmd.start    = 1'b0;
        cmd.dividend = value_reg;
        cmd.divisor  = div_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    div_next   = FIRST_DIVISOR;
                    sq_next    = FIRST_SQUARE;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (value_reg < SMALLEST_PRIME) begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end else if (sq_reg > {1'b0, value_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (sts.done) begin
                    if (sts.zero) begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        // (d + 1)^2 = d^2 + 2d + 1
                        div_next   = div_reg + 1'b1;
                        sq_next    = sq_reg + SQ_W'({div_reg, 1'b1});
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_prime = prime_reg;

endmodule

`default_nettype wire

// ----- design/prime_count_trial_division.sv -----
// Primality tester with a per-packet prime count. Each input beat carries one
// unsigned 32-bit value; the block tests it by trial division with divisors
// 2, 3, 4, ... while the divisor squared stays at or below the value, and stops
// at the first divisor that divides it. Zero and one are reported not prime.
// Each result beat gives the prime flag, the primes counted so far in the
// current packet of PACKET_LENGTH values (saturating at 15), and a mark on the
// last beat of each packet. One value is in work at a time: s_ready is low from
// acceptance until the result moves into the output register. Values below 4
// finish without a remainder pass; every other value runs the bit-serial
// remainder unit once per divisor tried, 32 steps each, plus issue and check.
// The output register lets the next value start while the previous result
// waits for m_ready.
`default_nettype none

module prime_count_trial_division
    import pctd_pkg::*;
#(
    parameter int unsigned PACKET_LENGTH = 10
)
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_is_prime,
    output logic [TALLY_W-1:0]      m_packet_primes,
    output logic                    m_packet_end
);

    localparam int unsigned POS_W = (PACKET_LENGTH > 1) ? $clog2(PACKET_LENGTH) : 1;

    rem_cmd_t rem_cmd;
    rem_sts_t rem_sts;

    logic seq_idle;
    logic res_valid;
    logic res_prime;
    logic res_take;

    logic               m_valid_reg;
    logic               is_prime_reg;
    logic               end_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [TALLY_W-1:0] tally_base;
    logic               last;

    assign s_ready = seq_idle;

    pctd_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && s_ready),
        .value     (s_value),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_prime (res_prime),
        .res_take  (res_take),
        .cmd       (rem_cmd),
        .sts       (rem_sts)
    );

    pctd_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rem_cmd),
        .sts     (rem_sts)
    );

    // A finished result moves into the output register once that is free.
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    // Packet position and prime tally; the tally restarts with each packet.
    always_comb begin
        last       = (pos_reg == POS_W'(PACKET_LENGTH - 1));
        pos_next   = last ? '0 : pos_reg + 1'b1;
        tally_base = (pos_reg == '0) ? '0 : tally_reg;
        if (res_prime && (tally_base != TALLY_MAX)) begin
            tally_next = tally_base + 1'b1;
        end else begin
            tally_next = tally_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            tally_reg   <= '0;
        end else begin
            if (res_take) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= pos_next;
                tally_reg   <= tally_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            is_prime_reg <= res_prime;
            end_reg      <= last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_prime      = is_prime_reg;
    assign m_packet_primes = tally_reg;
    assign m_packet_end    = end_reg;

endmodule

`default_nettype wire

// ----- design/pctd_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the prime tester.
module pctd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_is_prime,
    input wire logic [3:0] m_packet_primes,
    input wire logic       m_packet_end
);

    // No result beat is offered right after reset.
    `PCTD_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result beat holds its payload.
    `PCTD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_is_prime) && $stable(m_packet_primes) && $stable(m_packet_end), "stalled result changed")

    // The tester works on one value at a time.
    `PCTD_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready right after accept")

    // A prime result never reports a zero prime count for its packet.
    `PCTD_ASSERT(a_prime_counted, m_valid && m_is_prime |-> m_packet_primes != 4'd0, "prime not counted")

endmodule

bind prime_count_trial_division pctd_checker u_checker (.*);

`default_nettype wire
